FILE: src/gfir_pkg.sv
`default_nettype none
package gfir_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int MAX_TAPS  = 8;
  localparam int NUM_COEF  = 8;
  localparam int PROD_W    = SAMPLE_W + COEF_W + 1;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int ACC_W     = PROD_W + 3;
  localparam int QBITS     = 15;
  localparam int SHIFT_W   = ACC_W - QBITS;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [PAIR_W-1:0]   pair_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [SHIFT_W-1:0]  shift_t;

  typedef logic [$clog2(NUM_COEF)-1:0] reg_idx_t;

  localparam acc_t    ROUND_HALF = acc_t'(1) <<< (QBITS - 1);
  localparam shift_t  SAT_MAX    = shift_t'(32767);
  localparam shift_t  SAT_MIN    = -shift_t'(32768);
  localparam coef_t   COEF_RESET = coef_t'(4096);

  typedef struct packed {
    logic valid;
  } hs_t;

endpackage
`default_nettype wire

FILE: src/gfir_regs.sv
`default_nettype none
module gfir_regs #(
  parameter int TAPS = 8
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [gfir_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire  [gfir_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [gfir_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output gfir_pkg::coef_t [TAPS-1:0]       coefs
);

  gfir_pkg::coef_t [gfir_pkg::NUM_COEF-1:0] coef_r;
  gfir_pkg::reg_idx_t                       idx;
  logic                                     wr_en;

  assign idx    = paddr[gfir_pkg::APB_ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = {{(gfir_pkg::APB_DATA_W-gfir_pkg::COEF_W){1'b0}}, coef_r[idx]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gfir_pkg::NUM_COEF; i++) begin
        coef_r[i] <= gfir_pkg::COEF_RESET;
      end
    end else if (wr_en) begin
      coef_r[idx] <= pwdata[gfir_pkg::COEF_W-1:0];
    end
  end

  assign coefs = coef_r[TAPS-1:0];

endmodule
`default_nettype wire

FILE: src/gfir_mult.sv
`default_nettype none
module gfir_mult #(
  parameter int TAPS = 8
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  gfir_pkg::sample_t                sample,
  input  gfir_pkg::coef_t [TAPS-1:0]       coefs,
  output gfir_pkg::hs_t                    hs_down,
  input  wire                              down_ready,
  output gfir_pkg::prod_t [TAPS-1:0]       prods
);

  gfir_pkg::sample_t [TAPS-2:0] dl_r;
  gfir_pkg::sample_t [TAPS-1:0] win_r;
  gfir_pkg::prod_t   [TAPS-1:0] prod_r;
  gfir_pkg::prod_t   [TAPS-1:0] prod_nxt;
  logic                         v1_r;
  logic                         v2_r;
  logic                         adv1;
  logic                         adv2;
  logic                         acc_in;

  assign adv2     = !v2_r || down_ready;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;
  assign acc_in   = in_valid && adv1;

  // delay line shifts once per input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_r <= '0;
    end else if (acc_in) begin
      dl_r[0] <= sample;
      for (int k = 1; k < TAPS - 1; k++) begin
        dl_r[k] <= dl_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      win_r[0] <= sample;
      for (int k = 1; k < TAPS; k++) begin
        win_r[k] <= dl_r[k-1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      prod_nxt[k] = gfir_pkg::prod_t'(win_r[k]) * gfir_pkg::prod_t'($signed({1'b0, coefs[k]}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign hs_down.valid = v2_r;
  assign prods         = prod_r;

endmodule
`default_nettype wire

FILE: src/gfir_sum.sv
`default_nettype none
module gfir_sum #(
  parameter int TAPS = 8
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  gfir_pkg::hs_t                    hs_up,
  output logic                             up_ready,
  input  gfir_pkg::prod_t [TAPS-1:0]       prods,
  output logic                             out_valid,
  input  wire                              out_ready,
  output gfir_pkg::sample_t                result
);

  localparam int NPAIR = gfir_pkg::MAX_TAPS / 2;

  gfir_pkg::prod_t   [gfir_pkg::MAX_TAPS-1:0] pad;
  gfir_pkg::pair_t   [NPAIR-1:0]              pair_r;
  gfir_pkg::acc_t                             tot_r;
  gfir_pkg::acc_t                             tot_nxt;
  gfir_pkg::acc_t                             rnd;
  gfir_pkg::shift_t                           shf;
  gfir_pkg::sample_t                          res_r;
  gfir_pkg::sample_t                          res_nxt;
  logic                                       v3_r;
  logic                                       v4_r;
  logic                                       v5_r;
  logic                                       adv3;
  logic                                       adv4;
  logic                                       adv5;

  for (genvar j = 0; j < gfir_pkg::MAX_TAPS; j++) begin : g_pad
    if (j < TAPS) begin : g_tap
      assign pad[j] = prods[j];
    end else begin : g_zero
      assign pad[j] = '0;
    end
  end

  assign adv5     = !v5_r || out_ready;
  assign adv4     = !v4_r || adv5;
  assign adv3     = !v3_r || adv4;
  assign up_ready = adv3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv3) v3_r <= hs_up.valid;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && hs_up.valid) begin
      for (int p = 0; p < NPAIR; p++) begin
        pair_r[p] <= gfir_pkg::pair_t'(pad[2*p]) + gfir_pkg::pair_t'(pad[2*p+1]);
      end
    end
  end

  always_comb begin
    tot_nxt = '0;
    for (int p = 0; p < NPAIR; p++) begin
      tot_nxt = tot_nxt + gfir_pkg::acc_t'(pair_r[p]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv4 && v3_r) begin
      tot_r <= tot_nxt;
    end
  end

  // round half up, then saturate
  assign rnd = tot_r + gfir_pkg::ROUND_HALF;
  assign shf = rnd[gfir_pkg::ACC_W-1:gfir_pkg::QBITS];

  always_comb begin
    priority if (shf > gfir_pkg::SAT_MAX) begin
      res_nxt = gfir_pkg::sample_t'(gfir_pkg::SAT_MAX);
    end else if (shf < gfir_pkg::SAT_MIN) begin
      res_nxt = gfir_pkg::sample_t'(gfir_pkg::SAT_MIN);
    end else begin
      res_nxt = shf[gfir_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv5 && v4_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = v5_r;
  assign result    = res_r;

endmodule
`default_nettype wire

FILE: src/gaussian_fir_filter_unit.sv
// Gaussian smoothing FIR filter, TAPS Q1.15 weights, one output per input.
// Input stream: in_tvalid/in_tready/in_tdata carries one signed 16-bit
// sample per transfer. Output stream: out_tvalid/out_tready/out_tdata
// carries the filtered sample, rounded to nearest (ties up) and saturated.
// Weights coef_0..coef_7 sit on the APB port at byte address 4*i; write
// them only while the filter is idle. coef_0 weights the newest sample.
// An input sample passes through window capture, multiply, pair add,
// final add and the round/saturate register before out_tvalid rises.
// Throughput: one sample per cycle while out_tready is high; the five
// pipeline registers each hold a valid bit and advance independently,
// so bubbles are squeezed out.
// When out_tready is low the pipeline fills up and in_tready falls once
// every stage holds data; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears the delay line to zero, sets all
// weights to 4096 (0.125) and empties the pipeline. During warm-up the
// missing older samples count as zero.
`default_nettype none
module gaussian_fir_filter_unit #(
  parameter int TAPS = 8
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [15:0]                      in_tdata,   // [15:0] sample_in
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [15:0]                      out_tdata,  // [15:0] filtered_out
  input  wire                              cfg_psel,
  input  wire                              cfg_penable,
  input  wire                              cfg_pwrite,
  input  wire  [gfir_pkg::APB_ADDR_W-1:0]  cfg_paddr,
  input  wire  [gfir_pkg::APB_DATA_W-1:0]  cfg_pwdata,
  output logic [gfir_pkg::APB_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  gfir_pkg::coef_t [TAPS-1:0] coefs;
  gfir_pkg::prod_t [TAPS-1:0] prods;
  gfir_pkg::hs_t              hs_mid;
  gfir_pkg::sample_t          result;
  logic                       mid_ready;

  gfir_regs #(.TAPS(TAPS)) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .coefs   (coefs)
  );

  gfir_mult #(.TAPS(TAPS)) u_mult (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .sample     (gfir_pkg::sample_t'(in_tdata)),
    .coefs      (coefs),
    .hs_down    (hs_mid),
    .down_ready (mid_ready),
    .prods      (prods)
  );

  gfir_sum #(.TAPS(TAPS)) u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .hs_up     (hs_mid),
    .up_ready  (mid_ready),
    .prods     (prods),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .result    (result)
  );

  assign out_tdata = result;

endmodule
`default_nettype wire
